>>> rtl/core/nsc_pkg.sv
package nsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = COORD_W + 1;
  localparam int CHROMA_W  = COORD_W - 1;
  localparam int STEP_W    = DIM_W + FRAC_BITS;
  localparam int PROD_W    = COORD_W + STEP_W;
  localparam int POS_W     = PROD_W - FRAC_BITS + 1;
  localparam int REM_W     = DIM_W + 1;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);
  localparam int CFG_IDX_W = 3;

  // Any accumulated column at or above this value clamps to the last source column.
  localparam logic [STEP_W-1:0] ACC_SAT = STEP_W'(MAX_DIM) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_WIDTH,
    CFG_OUT_HEIGHT,
    CFG_CROP_X,
    CFG_CROP_Y,
    CFG_USED_WIDTH,
    CFG_USED_HEIGHT,
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_steps;
    logic mul_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic steps_ready;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [DIM_W-1:0] eff_out(input logic [DIM_W-1:0] v);
    if (v > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_src(input logic [POS_W-1:0] pos,
                                                   input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] lim;
    lim = size;
    if (lim == '0) begin
      lim = DIM_W'(1);
    end
    if (lim > DIM_W'(MAX_DIM)) begin
      lim = DIM_W'(MAX_DIM);
    end
    if (pos >= POS_W'(lim)) begin
      return COORD_W'(lim - DIM_W'(1));
    end
    return pos[COORD_W-1:0];
  endfunction

endpackage

>>> rtl/core/nsc_in_if.sv
interface nsc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

>>> rtl/core/nsc_out_if.sv
interface nsc_out_if;
  import nsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  out_col;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  src_col;
  logic [COORD_W-1:0]  src_row;
  logic [CHROMA_W-1:0] chroma_col;
  logic [CHROMA_W-1:0] chroma_row;
  logic                row_end;
  logic                frame_end;

  modport source (output valid, output out_col, output out_row, output src_col,
                  output src_row, output chroma_col, output chroma_row,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input out_col, input out_row, input src_col,
                input src_row, input chroma_col, input chroma_row,
                input row_end, input frame_end, output ready);
endinterface

>>> rtl/core/nsc_div.sv
module nsc_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [1:0][nsc_pkg::STEP_W-1:0]       dividend,
  input  logic [1:0][nsc_pkg::DIM_W-1:0]        divisor,
  output logic [1:0][nsc_pkg::STEP_W-1:0]       quotient,
  output logic                                  done
);
  import nsc_pkg::*;

  // Two restoring dividers side by side, one quotient bit per cycle each.
  // The quotient register first holds the dividend and shifts it out MSB first.
  logic [1:0][REM_W-1:0]  rem_r, rem_nxt;
  logic [1:0][STEP_W-1:0] quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [1:0][REM_W-1:0]  shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = '0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DIV_CNT_W'(STEP_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        shifted[i] = {rem_r[i][REM_W-2:0], quo_r[i][STEP_W-1]};
        if (shifted[i] >= REM_W'(divisor[i])) begin
          rem_nxt[i] = shifted[i] - REM_W'(divisor[i]);
          quo_nxt[i] = {quo_r[i][STEP_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = shifted[i];
          quo_nxt[i] = {quo_r[i][STEP_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> rtl/core/nsc_datapath.sv
module nsc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nsc_pkg::cmd_t                   cmd,
  output nsc_pkg::status_t                status,
  input  logic                            in_restart,
  input  logic                            cfg_we,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsc_pkg::DIM_W-1:0]       cfg_data,
  nsc_out_if.source                       out_ch
);
  import nsc_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0]   out_width_r, out_height_r, used_width_r, used_height_r;
  logic [DIM_W-1:0]   src_width_r, src_height_r;
  logic [COORD_W-1:0] crop_x_r, crop_y_r;

  // Walk state.
  logic [COORD_W-1:0] col_count_r, col_count_nxt;
  logic [COORD_W-1:0] row_count_r, row_count_nxt;
  logic [STEP_W-1:0]  col_accum_r, col_accum_nxt;
  logic               steps_ready_r, steps_ready_nxt;
  logic [STEP_W-1:0]  col_step_r, row_step_r;
  logic [PROD_W-1:0]  prod_r;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0]  out_col_r, out_row_r, src_col_r, src_row_r;
  logic                row_end_r, frame_end_r;

  logic [DIM_W-1:0]        eff_w, eff_h;
  logic [1:0][STEP_W-1:0]  div_dividend, div_quotient;
  logic [1:0][DIM_W-1:0]   div_divisor;
  logic                    div_done;
  logic [STEP_W:0]         accum_sum;
  logic [POS_W-1:0]        col_pos, row_pos;
  logic [COORD_W-1:0]      sc, sr;
  logic                    rend, fend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r   <= '0;
      out_height_r  <= '0;
      crop_x_r      <= '0;
      crop_y_r      <= '0;
      used_width_r  <= '0;
      used_height_r <= '0;
      src_width_r   <= DIM_W'(1);
      src_height_r  <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OUT_WIDTH:   out_width_r   <= cfg_data;
        CFG_OUT_HEIGHT:  out_height_r  <= cfg_data;
        CFG_CROP_X:      crop_x_r      <= cfg_data[COORD_W-1:0];
        CFG_CROP_Y:      crop_y_r      <= cfg_data[COORD_W-1:0];
        CFG_USED_WIDTH:  used_width_r  <= cfg_data;
        CFG_USED_HEIGHT: used_height_r <= cfg_data;
        CFG_SRC_WIDTH:   src_width_r   <= cfg_data;
        CFG_SRC_HEIGHT:  src_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = eff_out(out_width_r);
  assign eff_h = eff_out(out_height_r);

  assign div_dividend[0] = {used_width_r, FRAC_BITS'(0)};
  assign div_dividend[1] = {used_height_r, FRAC_BITS'(0)};
  assign div_divisor[0]  = eff_w;
  assign div_divisor[1]  = eff_h;

  nsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // The column accumulator saturates once its integer part reaches the
  // largest source size, since every such position clamps the same way.
  assign accum_sum = {1'b0, col_accum_r} + {1'b0, col_step_r};

  assign col_pos = POS_W'(crop_x_r) + POS_W'(col_accum_r >> FRAC_BITS);
  assign row_pos = POS_W'(crop_y_r) + POS_W'(prod_r >> FRAC_BITS);
  assign sc      = clamp_src(col_pos, src_width_r);
  assign sr      = clamp_src(row_pos, src_height_r);
  assign rend    = ({1'b0, col_count_r} + DIM_W'(1)) >= eff_w;
  assign fend    = rend && (({1'b0, row_count_r} + DIM_W'(1)) >= eff_h);

  always_comb begin
    col_count_nxt   = col_count_r;
    row_count_nxt   = row_count_r;
    col_accum_nxt   = col_accum_r;
    steps_ready_nxt = steps_ready_r;
    if (cmd.accept && (in_restart || !status.enable)) begin
      col_count_nxt   = '0;
      row_count_nxt   = '0;
      col_accum_nxt   = '0;
      steps_ready_nxt = 1'b0;
    end
    if (cmd.load_steps) begin
      col_accum_nxt   = '0;
      steps_ready_nxt = 1'b1;
    end
    if (cmd.emit) begin
      if (rend) begin
        col_count_nxt = '0;
        col_accum_nxt = '0;
        if (fend) begin
          row_count_nxt   = '0;
          steps_ready_nxt = 1'b0;
        end else begin
          row_count_nxt = row_count_r + COORD_W'(1);
        end
      end else begin
        col_count_nxt = col_count_r + COORD_W'(1);
        if (accum_sum >= (STEP_W + 1)'(ACC_SAT)) begin
          col_accum_nxt = ACC_SAT;
        end else begin
          col_accum_nxt = accum_sum[STEP_W-1:0];
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r   <= '0;
      row_count_r   <= '0;
      col_accum_r   <= '0;
      steps_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      col_count_r   <= col_count_nxt;
      row_count_r   <= row_count_nxt;
      col_accum_r   <= col_accum_nxt;
      steps_ready_r <= steps_ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_steps) begin
      col_step_r <= div_quotient[0];
      row_step_r <= div_quotient[1];
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(row_count_r) * PROD_W'(row_step_r);
    end
    if (cmd.emit) begin
      out_col_r   <= col_count_r;
      out_row_r   <= row_count_r;
      src_col_r   <= sc;
      src_row_r   <= sr;
      row_end_r   <= rend;
      frame_end_r <= fend;
    end
  end

  assign status.enable      = (eff_w != '0) && (eff_h != '0) &&
                              (used_width_r != '0) && (used_height_r != '0);
  assign status.steps_ready = steps_ready_r;
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.src_col    = src_col_r;
  assign out_ch.src_row    = src_row_r;
  assign out_ch.chroma_col = src_col_r[COORD_W-1:1];
  assign out_ch.chroma_row = src_row_r[COORD_W-1:1];
  assign out_ch.row_end    = row_end_r;
  assign out_ch.frame_end  = frame_end_r;

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    steps_ready_r |-> (row_step_r != '0) && (col_step_r != '0))
    else $error("steps marked ready while a step is zero");

  a_accum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_accum_r <= ACC_SAT)
    else $error("column accumulator beyond saturation value");

  a_frame_end_home: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && fend |=> !steps_ready_r && (row_count_r == '0) && (col_count_r == '0))
    else $error("walk not home after frame end");

  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !rend |=> col_count_r == $past(col_count_r) + COORD_W'(1))
    else $error("column counter did not advance");

endmodule

>>> rtl/core/nsc_ctrl.sv
module nsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nsc_pkg::status_t  status,
  output nsc_pkg::cmd_t     cmd
);
  import nsc_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = status.enable ? ST_MUL : ST_IDLE;
        end
      end
      ST_MUL: begin
        state_nxt = status.steps_ready ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MUL: begin
        cmd.div_start = !status.steps_ready;
        cmd.mul_load  = status.steps_ready;
      end
      ST_DIV: begin
        cmd.load_steps = status.div_done;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_only_when_needed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.steps_ready)
    else $error("divide started with steps already valid");

  a_emit_needs_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.steps_ready)
    else $error("result produced without valid steps");

endmodule

>>> rtl/core/nearest_scale_coordinate_gen.sv
// An input transfer leads to the row multiply, then to the load of the output register
// (row multiply, then output load); at a frame start the two step divisions come
// first, one quotient bit per cycle from two parallel restoring dividers.
// The controller sequence around the row multiplier takes no new pixel until the current
// one is loaded and waits while the output register is full; a zero size gives no result.
// Reset (synchronous, rst_n low) homes the walk and loads the register defaults.
module nearest_scale_coordinate_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  nsc_in_if.sink                          in_ch,
  nsc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nsc_pkg::DIM_W-1:0]       cfg_data
);
  import nsc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  nsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nsc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_restart (in_ch.restart),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ch     (out_ch)
  );

endmodule
